// File: hw/rtl/mqtt_topic_filter_matcher_defines.svh
// Assertion macros for the MQTT topic filter matcher.
// Included by the top level; needs clk and arst_n in the including scope.
`ifndef MQTT_TOPIC_FILTER_MATCHER_DEFINES_SVH
`define MQTT_TOPIC_FILTER_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define MTFM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mtfm assertion failed");
// Checked at every edge, reset included.
`define MTFM_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("mtfm assertion failed");
`else
`define MTFM_ASSERT(label, prop)
`define MTFM_ASSERT_ALWAYS(label, prop)
`endif

`endif

// File: hw/rtl/mtfm_pkg.sv
// Types and constants for the MQTT topic filter matcher.
// Standalone package; used by mqtt_topic_filter_matcher.
package mtfm_pkg;

	// Default filter store depth in bytes.
	localparam int MTFM_FILTER_CAPACITY = 64;

	// Request kinds.
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_NAME = 1'b1;

	// Characters with a meaning in topic filters.
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_HASH  = 8'h23;

	// Matching mode while a topic name streams in.
	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_PLUS   = 2'd1,
		MODE_HASH   = 2'd2,
		MODE_FAILED = 2'd3
	} match_mode_t;

	// One incoming request: a filter byte or a topic name byte.
	typedef struct packed {
		logic       req_type;
		logic [7:0] text_char;
		logic       is_last;
	} mtfm_req_t;

	// One match result.
	typedef struct packed {
		logic matched;
		logic filter_overflow;
	} mtfm_rsp_t;

endpackage

// File: hw/rtl/mqtt_topic_filter_matcher.sv
// MQTT topic filter matcher: filter store, streaming name compare, result buffer.
// Depends on mtfm_pkg and mqtt_topic_filter_matcher_defines.svh.

// The block takes one request per clock: a filter byte is written into the filter
// store, a name byte is compared against the filter byte at the current position, and
// the last name byte produces one result. The store is a synchronous memory whose read
// for the next filter position is issued ahead from the next-state position,
// so a name byte finds its filter byte ready; a filter load that writes the entry being
// read is bypassed into the compare. Results pass through a two-entry output buffer, so
// requests keep flowing while one result waits; only with both entries full does
// req_ready drop. Every request completes in the cycle it is accepted; a result is
// registered into the output buffer. The store needs no clearing after reset.
`include "mqtt_topic_filter_matcher_defines.svh"

module mqtt_topic_filter_matcher
	import mtfm_pkg::*;
#(
	parameter int FILTER_CAPACITY = MTFM_FILTER_CAPACITY
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  mtfm_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output mtfm_rsp_t rsp
);

	localparam int AW = $clog2(FILTER_CAPACITY);
	localparam int PW = $clog2(FILTER_CAPACITY + 1);
	localparam logic [PW-1:0] CAP = PW'(FILTER_CAPACITY);

	// Filter store and its registered read port.
	logic [7:0] mem [FILTER_CAPACITY];
	logic [7:0] rd_data_q;
	logic       fwd_valid_q;
	logic [7:0] fwd_data_q;

	// Control state.
	logic [PW-1:0] flen_q, lp_q, fp_q;
	logic [PW-1:0] flen_d, lp_d, fp_d;
	logic          ovf_q, ovf_d;
	match_mode_t   mode_q, mode_d;

	// Output buffer: main register and skid entry.
	logic      rsp_valid_q, skid_valid_q;
	mtfm_rsp_t rsp_q, skid_q, new_rsp;

	logic       accept, is_load, is_name, push, pop;
	logic       wr_en, do_cmp, cmp_fail;
	logic [7:0] wr_data, fbyte, c;
	logic [AW-1:0] wr_addr, rd_addr;

	assign accept  = req_valid && req_ready;
	assign is_load = accept && (req.req_type == REQ_LOAD);
	assign is_name = accept && (req.req_type == REQ_NAME);
	assign c       = req.text_char;

	// The filter byte at the current position, with the bypass for a recent load.
	assign fbyte = fwd_valid_q ? fwd_data_q : rd_data_q;

	// Store write for a filter byte that fits.
	assign wr_en   = is_load && (lp_q < CAP);
	assign wr_addr = lp_q[AW-1:0];
	assign wr_data = c;
	assign rd_addr = fp_d[AW-1:0];

	// Next state for loading and name compare.
	always_comb begin
		flen_d   = flen_q;
		lp_d     = lp_q;
		ovf_d    = ovf_q;
		fp_d     = fp_q;
		mode_d   = mode_q;
		do_cmp   = 1'b0;
		cmp_fail = 1'b0;
		new_rsp  = '0;
		if (is_load) begin
			if (lp_q >= CAP) begin
				ovf_d = 1'b1;
			end else begin
				if (lp_q == '0) begin
					ovf_d = 1'b0;
				end
				lp_d   = lp_q + PW'(1);
				flen_d = lp_q + PW'(1);
			end
			if (req.is_last) begin
				lp_d = '0;
			end
		end
		if (is_name) begin
			do_cmp = (mode_q == MODE_NORMAL) ||
				((mode_q == MODE_PLUS) && (c == CH_SLASH));
			if (do_cmp) begin
				mode_d = MODE_NORMAL;
				if (fp_q >= flen_q) begin
					cmp_fail = 1'b1;
				end else if ((c == CH_SLASH) && (fbyte != CH_SLASH)) begin
					cmp_fail = 1'b1;
				end else if ((fbyte != CH_PLUS) && (fbyte != CH_HASH) && (fbyte != c)) begin
					cmp_fail = 1'b1;
				end
				if (cmp_fail) begin
					mode_d = MODE_FAILED;
				end else begin
					fp_d = fp_q + PW'(1);
					if (fbyte == CH_PLUS) begin
						mode_d = MODE_PLUS;
					end else if (fbyte == CH_HASH) begin
						mode_d = MODE_HASH;
					end
				end
			end
			// End of name: report, then rewind for the next name.
			new_rsp.matched = (mode_d != MODE_FAILED) && (fp_d == flen_q) && !ovf_q;
			new_rsp.filter_overflow = ovf_q;
			if (req.is_last) begin
				fp_d   = '0;
				mode_d = MODE_NORMAL;
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flen_q <= '0;
			lp_q   <= '0;
			fp_q   <= '0;
			ovf_q  <= 1'b0;
			mode_q <= MODE_NORMAL;
		end else begin
			flen_q <= flen_d;
			lp_q   <= lp_d;
			fp_q   <= fp_d;
			ovf_q  <= ovf_d;
			mode_q <= mode_d;
		end
	end

	// Filter store: read-before-write, read address follows the next position.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q  <= mem[rd_addr];
		fwd_data_q <= wr_data;
	end

	// A write to the entry being read is bypassed on the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	// Output buffer control.
	assign push      = is_name && req.is_last;
	assign pop       = rsp_valid_q && rsp_ready;
	assign req_ready = !skid_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= push;
				end else begin
					rsp_valid_q <= push;
				end
			end else if (!rsp_valid_q) begin
				rsp_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Output buffer payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				rsp_q <= skid_q;
				if (push) begin
					skid_q <= new_rsp;
				end
			end else if (push) begin
				rsp_q <= new_rsp;
			end
		end else if (!rsp_valid_q) begin
			if (push) begin
				rsp_q <= new_rsp;
			end
		end else if (push) begin
			skid_q <= new_rsp;
		end
	end

	// Checks on the buffer, the load pointer, the name rewind and the result.
	`MTFM_ASSERT_ALWAYS(a_skid_needs_main, skid_valid_q |-> rsp_valid_q)
	`MTFM_ASSERT(a_load_pos_bound, lp_q <= CAP)
	`MTFM_ASSERT(a_name_rewind, push |=> (mode_q == MODE_NORMAL) && (fp_q == '0))
	`MTFM_ASSERT(a_ovf_no_match, rsp_valid_q && rsp_q.filter_overflow |-> !rsp_q.matched)

endmodule

// File: tb/mtfm_match_checker.sv
// Match checker for the MQTT topic filter matcher: watches the request and response channels,
// predicts each match result from the loaded filter and compares it with the block.
// Depends on mtfm_pkg; instantiated beside the block by tb_top.
module mtfm_match_checker
	import mtfm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  mtfm_req_t req,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  mtfm_rsp_t rsp,
	output int        mismatch_count,
	output int        pending_results
);

	// Shadow copy of the filter store and the matching state.
	logic [7:0]  filter_mem [MTFM_FILTER_CAPACITY];
	int          filter_len;
	int          load_pos;
	int          filter_pos;
	match_mode_t mode;
	logic        overflow;

	// Match results still owed by the block, oldest first.
	mtfm_rsp_t   match_results_q[$];

	// A filter byte lands in the store unless the store is full.
	function automatic void load_filter_char(logic [7:0] c, logic last);
		if (load_pos == 0) begin
			overflow = 1'b0;
		end
		if (load_pos < MTFM_FILTER_CAPACITY) begin
			filter_mem[load_pos] = c;
			load_pos++;
			filter_len = load_pos;
		end else begin
			overflow = 1'b1;
		end
		if (last) begin
			load_pos = 0;
		end
	endfunction

	// Compare one name byte against the filter byte at the current position.
	function automatic void compare_name_char(logic [7:0] c);
		logic [7:0] f;
		if (filter_pos >= filter_len || filter_pos >= MTFM_FILTER_CAPACITY) begin
			mode = MODE_FAILED;
			return;
		end
		f = filter_mem[filter_pos];
		if (c == CH_SLASH && f != CH_SLASH) begin
			mode = MODE_FAILED;
			return;
		end
		if (f != CH_PLUS && f != CH_HASH && f != c) begin
			mode = MODE_FAILED;
			return;
		end
		filter_pos++;
		if (f == CH_PLUS) begin
			mode = MODE_PLUS;
		end else if (f == CH_HASH) begin
			mode = MODE_HASH;
		end
	endfunction

	// Advance the matching state by one name byte.
	function automatic void step_name_char(logic [7:0] c);
		case (mode)
			MODE_FAILED, MODE_HASH: begin
			end
			MODE_PLUS: begin
				// A slash closes the wildcard level and is compared normally.
				if (c == CH_SLASH) begin
					mode = MODE_NORMAL;
					compare_name_char(c);
				end
			end
			default: begin
				compare_name_char(c);
			end
		endcase
	endfunction

	// Compare accepted results first, then fold in the accepted request.
	always @(posedge clk or negedge arst_n) begin
		mtfm_rsp_t want;
		if (!arst_n) begin
			filter_len      = 0;
			load_pos        = 0;
			filter_pos      = 0;
			mode            = MODE_NORMAL;
			overflow        = 1'b0;
			mismatch_count  = 0;
			pending_results = 0;
			match_results_q.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (match_results_q.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("unexpected result: matched=%0b filter_overflow=%0b",
							rsp.matched, rsp.filter_overflow);
					end
					mismatch_count++;
				end else begin
					want = match_results_q.pop_front();
					if (rsp.matched !== want.matched ||
						rsp.filter_overflow !== want.filter_overflow) begin
						if (mismatch_count < 10) begin
							$display("result mismatch: matched exp %0b got %0b, %s%0b got %0b",
								want.matched, rsp.matched, "filter_overflow exp ",
								want.filter_overflow, rsp.filter_overflow);
						end
						mismatch_count++;
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req.req_type == REQ_LOAD) begin
					load_filter_char(req.text_char, req.is_last);
				end else begin
					step_name_char(req.text_char);
					if (req.is_last) begin
						want.matched = (mode != MODE_FAILED && filter_pos == filter_len &&
							!overflow);
						want.filter_overflow = overflow;
						match_results_q.push_back(want);
						filter_pos = 0;
						mode = MODE_NORMAL;
					end
				end
			end
			pending_results = match_results_q.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the MQTT topic filter matcher testbench: clock, reset, filter and name
// stimulus, receiver stalls and the verdict. Depends on mtfm_pkg, the block and
// mtfm_match_checker.
module tb_top;
	import mtfm_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	mtfm_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	mtfm_rsp_t rsp;
	int        mismatch_count;
	int        pending_results;

	// Idle rates in percent and the long receiver hold-off request.
	int        send_idle = 27;
	int        recv_idle = 64;
	logic      hold_go = 1'b0;
	logic      hold_done = 1'b0;
	int        item_count = 0;

	// Filter and name under construction.
	logic [7:0] filter_bytes[$];
	logic [7:0] name_bytes[$];

	mqtt_topic_filter_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	mtfm_match_checker u_match_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.rsp             (rsp),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	// Clock with a period of four units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Overall time limit.
	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offer one request, with random idle cycles ahead of it, until accepted.
	task automatic send_byte(input logic kind, input logic [7:0] c, input logic last);
		mtfm_req_t item;
		item.req_type  = kind;
		item.text_char = c;
		item.is_last   = last;
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		item_count++;
	endtask

	// Load the filter in filter_bytes, marking its final byte.
	task automatic load_filter();
		for (int i = 0; i < filter_bytes.size(); i++) begin
			send_byte(REQ_LOAD, filter_bytes[i], i == filter_bytes.size() - 1);
		end
	endtask

	// Stream the topic name in name_bytes, marking its final byte.
	task automatic send_name();
		for (int i = 0; i < name_bytes.size(); i++) begin
			send_byte(REQ_NAME, name_bytes[i], i == name_bytes.size() - 1);
		end
	endtask

	// Mostly a few plain letters, now and then any byte at all.
	function automatic logic [7:0] pick_char();
		if ($urandom_range(9) < 7) begin
			return 8'h61 + 8'($urandom_range(2));
		end
		return 8'($urandom_range(255));
	endfunction

	// A byte from pick_char that is never a slash.
	function automatic logic [7:0] pick_level_char();
		logic [7:0] c;
		c = pick_char();
		return (c == CH_SLASH) ? 8'h61 : c;
	endfunction

	// Build a random filter of one to four levels, some of them wildcards, or now and then a long one.
	task automatic make_filter();
		int levels;
		int kind;
		filter_bytes.delete();
		if ($urandom_range(39) == 0) begin
			// Long filter around the store capacity.
			repeat ($urandom_range(60, 70)) begin
				filter_bytes.push_back(($urandom_range(7) == 0) ? CH_SLASH : pick_char());
			end
			return;
		end
		levels = $urandom_range(1, 4);
		for (int l = 0; l < levels; l++) begin
			if (l != 0) begin
				filter_bytes.push_back(CH_SLASH);
			end
			kind = $urandom_range(9);
			if (kind < 2) begin
				filter_bytes.push_back(CH_PLUS);
			end else if (kind == 2) begin
				filter_bytes.push_back(CH_HASH);
			end else if (kind == 3) begin
				// Empty level.
			end else begin
				repeat ($urandom_range(1, 3)) begin
					filter_bytes.push_back(pick_char());
				end
			end
		end
		if (filter_bytes.size() == 0) begin
			filter_bytes.push_back(CH_HASH);
		end
	endtask

	// Build a name that fits the filter, then sometimes spoil it.
	task automatic make_name();
		int pos;
		name_bytes.delete();
		foreach (filter_bytes[i]) begin
			if (filter_bytes[i] == CH_PLUS) begin
				repeat (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3)) begin
					name_bytes.push_back(pick_level_char());
				end
			end else if (filter_bytes[i] == CH_HASH) begin
				repeat ($urandom_range(4)) begin
					name_bytes.push_back(($urandom_range(3) == 0) ? CH_SLASH : pick_char());
				end
			end else begin
				name_bytes.push_back(filter_bytes[i]);
			end
		end
		if (name_bytes.size() == 0) begin
			name_bytes.push_back(pick_char());
		end
		case ($urandom_range(11))
			0: begin
				pos = $urandom_range(name_bytes.size() - 1);
				name_bytes[pos] = ($urandom_range(1) != 0) ? CH_SLASH : pick_char();
			end
			1: begin
				name_bytes.push_back(($urandom_range(1) != 0) ? CH_SLASH : pick_char());
			end
			2: begin
				if (name_bytes.size() > 1) begin
					void'(name_bytes.pop_back());
				end
			end
			default: begin
			end
		endcase
	endtask

	// One random sequence: usually a filter with names against it, else noise.
	task automatic run_sequence();
		if ($urandom_range(99) < 12) begin
			repeat ($urandom_range(1, 6)) begin
				send_byte(1'($urandom_range(1)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
			end
		end else begin
			make_filter();
			load_filter();
			repeat ($urandom_range(1, 4)) begin
				make_name();
				send_name();
			end
		end
	endtask

	// Receiver: random stalls, and one long hold-off when asked for.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				for (int i = 0; i < 300; i++) begin
					rsp_ready <= 1'b0;
					@(posedge clk);
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Reset, directed cases, random phases, drain and verdict.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A name with no filter loaded never matches.
		send_byte(REQ_NAME, 8'h00, 1'b1);
		// Single-level wildcard, matched and against an empty level.
		filter_bytes = '{8'h61, CH_SLASH, CH_PLUS};
		load_filter();
		name_bytes = '{8'h61, CH_SLASH, 8'h62};
		send_name();
		name_bytes = '{8'h61, CH_SLASH};
		send_name();
		// Multi-level wildcard: a slash fails it, extreme bytes pass it.
		filter_bytes = '{CH_HASH};
		load_filter();
		send_byte(REQ_NAME, CH_SLASH, 1'b1);
		send_byte(REQ_NAME, 8'hFF, 1'b1);
		// A trailing multi-level wildcard needs its level to be present.
		filter_bytes = '{8'h61, CH_SLASH, CH_HASH};
		load_filter();
		send_byte(REQ_NAME, 8'h61, 1'b1);
		// A filter load in the middle of a name.
		send_byte(REQ_NAME, 8'h61, 1'b0);
		send_byte(REQ_LOAD, 8'h62, 1'b1);
		send_byte(REQ_NAME, 8'h63, 1'b1);

		// Random phases with different idle rates.
		while (item_count < 600) run_sequence();
		send_idle = 64;
		recv_idle = 27;
		while (item_count < 1200) run_sequence();
		send_idle = 0;
		recv_idle = 0;

		// Back-pressure: names keep coming while the receiver holds off.
		filter_bytes = '{CH_HASH};
		load_filter();
		hold_go <= 1'b1;
		repeat (40) begin
			send_byte(REQ_NAME, pick_char(), 1'b1);
		end
		while (item_count < 1750) run_sequence();
		req_valid <= 1'b0;

		// Drain outstanding results and let the bench go quiet before the verdict.
		while (pending_results != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
